// ===== rtl/core/bthalloc_pkg.sv =====
`timescale 1ns / 1ps

package bthalloc_pkg;

	localparam int TAG_W     = 12;
	localparam int SPAN_W    = 11;
	localparam int OCC_IDX   = 11;
	localparam int MIN_WORDS = 8;
	localparam int TAG_WORDS = 2;
	localparam int SPLIT_MIN = 4;
	localparam int GUARD_TAG_USED = 4;
	localparam logic [SPAN_W-1:0] COUNT_MAX = 11'd2047;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	typedef enum logic [4:0] {
		C_NONE,
		C_CLEAR,
		C_LOAD,
		C_RST0,
		C_RST1,
		C_RST2,
		C_RST3,
		C_ARD,
		C_ANEXT,
		C_SPLIT0,
		C_SPLIT1,
		C_SPLIT2,
		C_SPLIT3,
		C_UNS0,
		C_UNSR,
		C_UNSW,
		C_FRD,
		C_FHDR,
		C_FLEFT,
		C_FRIGHT,
		C_FW0,
		C_FW1
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic [1:0] op;
		logic       free_bad;
		logic       h_end;
		logic       bad;
		logic       fit;
		logic       split;
	} status_t;

	function automatic logic [SPAN_W-1:0] sat_add(input logic [SPAN_W-1:0] a,
		input logic [SPAN_W-1:0] b);
		logic [SPAN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SPAN_W] ? COUNT_MAX : s[SPAN_W-1:0];
	endfunction

	function automatic logic [SPAN_W-1:0] sat_sub(input logic [SPAN_W-1:0] a,
		input logic [SPAN_W-1:0] b);
		return (b > a) ? '0 : a - b;
	endfunction

endpackage

// ===== rtl/core/boundary_tag_heap_allocator.sv =====
`timescale 1ns / 1ps

// Boundary-tag heap allocator, first fit with coalescing, one word in and one result word out.
// After reset the tag store is swept to zero, one word a cycle, and then rebuilt as one free
// chunk; no word is taken meanwhile. An allocate reads and checks each chunk header visited
// (one tag-store read and its check) and then marks the chunk or splits it. heap_words is
// taken only while the block is idle and takes effect at the next heap reset operation.
module boundary_tag_heap_allocator #(
	parameter int HEAP_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,    // heap_words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,     // operation, request_words, block_address, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata      // granted, payload_address, used_words, zero pad
);

	logic [10:0]           heap_words_q;
	bthalloc_pkg::cmd_t    cmd;
	bthalloc_pkg::status_t status;
	logic                  granted;
	logic [9:0]            payload_address;
	logic [10:0]           used_words;

	assign cfg_ready = s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			heap_words_q <= 11'd1024;
		else if (cfg_valid && cfg_ready)
			heap_words_q <= cfg_data;
	end

	bthalloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bthalloc_dpath #(
		.HEAP_WORDS (HEAP_WORDS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_op           (s_tdata[1:0]),
		.in_req          (s_tdata[12:2]),
		.in_addr         (s_tdata[22:13]),
		.heap_words      (heap_words_q),
		.granted         (granted),
		.payload_address (payload_address),
		.used_words      (used_words)
	);

	assign m_tdata = {2'b00, used_words, payload_address, granted};

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("word accepted while previous one still in work");

	a_no_accept_with_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while a result is pending");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[10:1] == 10'd0)
		else $error("payload address set without grant");

endmodule

// ===== rtl/core/bthalloc_dpath.sv =====
`timescale 1ns / 1ps

module bthalloc_dpath #(
	parameter int HEAP_WORDS = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bthalloc_pkg::cmd_t      cmd,
	output bthalloc_pkg::status_t   status,
	input  logic [1:0]              in_op,
	input  logic [10:0]             in_req,
	input  logic [9:0]              in_addr,
	input  logic [10:0]             heap_words,
	output logic                    granted,
	output logic [9:0]              payload_address,
	output logic [10:0]             used_words
);

	localparam int IW = $clog2(HEAP_WORDS);
	localparam int PW = ((IW > 11) ? IW : 11) + 2;
	localparam int SW = bthalloc_pkg::SPAN_W;
	localparam int TW = bthalloc_pkg::TAG_W;

	logic [TW-1:0] mem [HEAP_WORDS];
	logic [TW-1:0] rdata_q;

	logic [1:0]    op_q;
	logic [SW-1:0] req_q;
	logic [9:0]    addr_q;
	logic [PW-1:0] h_q, ft_q, span_q, active_q;
	logic [SW-1:0] used_q;
	logic          granted_q;
	logic [9:0]    paddr_q;
	logic [IW-1:0] clr_q;

	logic [PW-1:0] hw, wc, last, rd_span, req_eff, s1, s2, h_plus1, rst_span;
	logic          rd_occ, left_ok, right_ok;
	logic          we;
	logic [PW-1:0] wa, ra;
	logic [TW-1:0] wd;
	logic [TW-1:0] s1_tag, s2_tag;

	always_comb begin
		hw = PW'(heap_words);
		if (hw < PW'(bthalloc_pkg::MIN_WORDS))
			wc = PW'(bthalloc_pkg::MIN_WORDS);
		else if (hw > PW'(HEAP_WORDS))
			wc = PW'(HEAP_WORDS);
		else
			wc = hw;
	end

	assign last     = active_q - PW'(1);
	assign rd_span  = PW'(rdata_q[SW-1:0]);
	assign rd_occ   = rdata_q[bthalloc_pkg::OCC_IDX];
	assign req_eff  = (req_q == '0) ? PW'(1) : PW'(req_q);
	assign s1       = req_eff + PW'(bthalloc_pkg::TAG_WORDS);
	assign s2       = span_q - s1;
	assign h_plus1  = h_q + PW'(1);
	assign rst_span = wc - PW'(bthalloc_pkg::TAG_WORDS);
	assign s1_tag   = {1'b1, s1[SW-1:0]};
	assign s2_tag   = {1'b0, s2[SW-1:0]};

	assign left_ok = (rdata_q != '0) && !rd_occ && (rd_span >= PW'(2))
		&& (rd_span <= h_q - PW'(1));
	assign right_ok = (ft_q + PW'(1) < last) && (rdata_q != '0) && !rd_occ
		&& (rd_span >= PW'(2)) && (ft_q + rd_span <= last - PW'(1));

	always_comb begin
		status.clr_last = (clr_q == IW'(HEAP_WORDS - 1));
		status.op       = op_q;
		status.free_bad = (addr_q < 10'd2) || (PW'(addr_q) - PW'(1) >= last);
		status.h_end    = (h_q >= last);
		status.bad      = (rd_span < PW'(2)) || (h_q + rd_span > last);
		status.fit      = !rd_occ && (rd_span >= req_eff + PW'(bthalloc_pkg::TAG_WORDS));
		status.split    = rd_span >= req_eff
			+ PW'(bthalloc_pkg::TAG_WORDS + bthalloc_pkg::SPLIT_MIN);
	end

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		ra = h_q;
		unique case (cmd)
			bthalloc_pkg::C_CLEAR: begin
				we = 1'b1;
				wa = PW'(clr_q);
			end
			bthalloc_pkg::C_RST0: begin
				we = 1'b1;
			end
			bthalloc_pkg::C_RST1: begin
				we = 1'b1;
				wa = wc - PW'(1);
			end
			bthalloc_pkg::C_RST2: begin
				we = 1'b1;
				wa = PW'(1);
				wd = {1'b0, rst_span[SW-1:0]};
			end
			bthalloc_pkg::C_RST3: begin
				we = 1'b1;
				wa = wc - PW'(2);
				wd = {1'b0, rst_span[SW-1:0]};
			end
			bthalloc_pkg::C_SPLIT0: begin
				we = 1'b1;
				wa = h_q;
				wd = s1_tag;
			end
			bthalloc_pkg::C_SPLIT1: begin
				we = 1'b1;
				wa = h_q + s1 - PW'(1);
				wd = s1_tag;
			end
			bthalloc_pkg::C_SPLIT2: begin
				we = 1'b1;
				wa = h_q + s1;
				wd = s2_tag;
			end
			bthalloc_pkg::C_SPLIT3: begin
				we = 1'b1;
				wa = h_q + span_q - PW'(1);
				wd = s2_tag;
			end
			bthalloc_pkg::C_UNS0: begin
				we = 1'b1;
				wa = h_q;
				wd = rdata_q | TW'(1 << bthalloc_pkg::OCC_IDX);
			end
			bthalloc_pkg::C_UNSR: begin
				ra = h_q + span_q - PW'(1);
			end
			bthalloc_pkg::C_UNSW: begin
				we = 1'b1;
				wa = h_q + span_q - PW'(1);
				wd = rdata_q | TW'(1 << bthalloc_pkg::OCC_IDX);
			end
			bthalloc_pkg::C_FHDR: begin
				ra = h_q - PW'(1);
			end
			bthalloc_pkg::C_FLEFT: begin
				ra = ft_q + PW'(1);
			end
			bthalloc_pkg::C_FW0: begin
				we = 1'b1;
				wa = h_q;
				wd = {1'b0, span_q[SW-1:0]};
			end
			bthalloc_pkg::C_FW1: begin
				we = 1'b1;
				wa = ft_q;
				wd = {1'b0, span_q[SW-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa[IW-1:0]] <= wd;
		rdata_q <= mem[ra[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			used_q    <= SW'(bthalloc_pkg::GUARD_TAG_USED);
			active_q  <= PW'(HEAP_WORDS);
			granted_q <= 1'b0;
			paddr_q   <= '0;
		end else begin
			unique case (cmd)
				bthalloc_pkg::C_CLEAR: begin
					clr_q <= clr_q + IW'(1);
				end
				bthalloc_pkg::C_LOAD: begin
					granted_q <= 1'b0;
					paddr_q   <= '0;
				end
				bthalloc_pkg::C_RST3: begin
					active_q <= wc;
					used_q   <= SW'(bthalloc_pkg::GUARD_TAG_USED);
				end
				bthalloc_pkg::C_SPLIT0: begin
					used_q <= bthalloc_pkg::sat_add(used_q, s1[SW-1:0]);
				end
				bthalloc_pkg::C_SPLIT3, bthalloc_pkg::C_UNSW: begin
					granted_q <= 1'b1;
					paddr_q   <= h_plus1[9:0];
				end
				bthalloc_pkg::C_UNS0: begin
					used_q <= bthalloc_pkg::sat_add(used_q, SW'(rd_span - PW'(2)));
				end
				bthalloc_pkg::C_FHDR: begin
					used_q <= bthalloc_pkg::sat_sub(used_q, SW'(rd_span - PW'(2)));
				end
				bthalloc_pkg::C_FLEFT: begin
					if (left_ok)
						used_q <= bthalloc_pkg::sat_sub(used_q, SW'(2));
				end
				bthalloc_pkg::C_FRIGHT: begin
					if (right_ok)
						used_q <= bthalloc_pkg::sat_sub(used_q, SW'(2));
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			bthalloc_pkg::C_LOAD: begin
				op_q   <= in_op;
				req_q  <= in_req;
				addr_q <= in_addr;
				h_q    <= (in_op == bthalloc_pkg::OP_FREE) ? PW'(in_addr) - PW'(1) : PW'(1);
			end
			bthalloc_pkg::C_ANEXT: begin
				h_q <= h_q + rd_span;
			end
			bthalloc_pkg::C_SPLIT0, bthalloc_pkg::C_UNS0: begin
				span_q <= rd_span;
			end
			bthalloc_pkg::C_FHDR: begin
				span_q <= rd_span;
				ft_q   <= h_q + rd_span - PW'(1);
			end
			bthalloc_pkg::C_FLEFT: begin
				if (left_ok) begin
					h_q    <= h_q - rd_span;
					span_q <= span_q + rd_span;
				end
			end
			bthalloc_pkg::C_FRIGHT: begin
				if (right_ok) begin
					ft_q   <= ft_q + rd_span;
					span_q <= span_q + rd_span;
				end
			end
			default: begin
			end
		endcase
	end

	assign granted         = granted_q;
	assign payload_address = paddr_q;
	assign used_words      = used_q;

endmodule

// ===== rtl/core/bthalloc_ctrl.sv =====
`timescale 1ns / 1ps

module bthalloc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  bthalloc_pkg::status_t status,
	output bthalloc_pkg::cmd_t    cmd
);

	typedef enum logic [22:0] {
		S_CLR    = 23'h000001,
		S_RST0   = 23'h000002,
		S_RST1   = 23'h000004,
		S_RST2   = 23'h000008,
		S_RST3   = 23'h000010,
		S_IDLE   = 23'h000020,
		S_DISP   = 23'h000040,
		S_ARD    = 23'h000080,
		S_ACHK   = 23'h000100,
		S_SPL0   = 23'h000200,
		S_SPL1   = 23'h000400,
		S_SPL2   = 23'h000800,
		S_SPL3   = 23'h001000,
		S_UNS0   = 23'h002000,
		S_UNSR   = 23'h004000,
		S_UNSW   = 23'h008000,
		S_FRD    = 23'h010000,
		S_FCHK   = 23'h020000,
		S_FLEFT  = 23'h040000,
		S_FRIGHT = 23'h080000,
		S_FW0    = 23'h100000,
		S_FW1    = 23'h200000,
		S_DONE   = 23'h400000
	} state_t;

	state_t state_q, state_d;
	logic   boot_q;
	logic   out_valid_q;

	assign s_tready = (state_q == S_IDLE) && !out_valid_q;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = bthalloc_pkg::C_NONE;
		unique case (state_q)
			S_CLR: begin
				cmd = bthalloc_pkg::C_CLEAR;
				if (status.clr_last)
					state_d = S_RST0;
			end
			S_RST0: begin
				cmd     = bthalloc_pkg::C_RST0;
				state_d = S_RST1;
			end
			S_RST1: begin
				cmd     = bthalloc_pkg::C_RST1;
				state_d = S_RST2;
			end
			S_RST2: begin
				cmd     = bthalloc_pkg::C_RST2;
				state_d = S_RST3;
			end
			S_RST3: begin
				cmd     = bthalloc_pkg::C_RST3;
				state_d = boot_q ? S_IDLE : S_DONE;
			end
			S_IDLE: begin
				if (s_tvalid && !out_valid_q) begin
					cmd     = bthalloc_pkg::C_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (status.op)
					bthalloc_pkg::OP_ALLOC: state_d = S_ARD;
					bthalloc_pkg::OP_FREE:  state_d = status.free_bad ? S_DONE : S_FRD;
					bthalloc_pkg::OP_RESET: state_d = S_RST0;
					default:                state_d = S_DONE;
				endcase
			end
			S_ARD: begin
				cmd     = bthalloc_pkg::C_ARD;
				state_d = status.h_end ? S_DONE : S_ACHK;
			end
			S_ACHK: begin
				if (status.bad)
					state_d = S_DONE;
				else if (status.fit)
					state_d = status.split ? S_SPL0 : S_UNS0;
				else begin
					cmd     = bthalloc_pkg::C_ANEXT;
					state_d = S_ARD;
				end
			end
			S_SPL0: begin
				cmd     = bthalloc_pkg::C_SPLIT0;
				state_d = S_SPL1;
			end
			S_SPL1: begin
				cmd     = bthalloc_pkg::C_SPLIT1;
				state_d = S_SPL2;
			end
			S_SPL2: begin
				cmd     = bthalloc_pkg::C_SPLIT2;
				state_d = S_SPL3;
			end
			S_SPL3: begin
				cmd     = bthalloc_pkg::C_SPLIT3;
				state_d = S_DONE;
			end
			S_UNS0: begin
				cmd     = bthalloc_pkg::C_UNS0;
				state_d = S_UNSR;
			end
			S_UNSR: begin
				cmd     = bthalloc_pkg::C_UNSR;
				state_d = S_UNSW;
			end
			S_UNSW: begin
				cmd     = bthalloc_pkg::C_UNSW;
				state_d = S_DONE;
			end
			S_FRD: begin
				cmd     = bthalloc_pkg::C_FRD;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				if (status.bad)
					state_d = S_DONE;
				else begin
					cmd     = bthalloc_pkg::C_FHDR;
					state_d = S_FLEFT;
				end
			end
			S_FLEFT: begin
				cmd     = bthalloc_pkg::C_FLEFT;
				state_d = S_FRIGHT;
			end
			S_FRIGHT: begin
				cmd     = bthalloc_pkg::C_FRIGHT;
				state_d = S_FW0;
			end
			S_FW0: begin
				cmd     = bthalloc_pkg::C_FW0;
				state_d = S_FW1;
			end
			S_FW1: begin
				cmd     = bthalloc_pkg::C_FW1;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			boot_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RST3)
				boot_q <= 1'b0;
			if (state_q == S_DONE)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
